/* rtl/core/lpd_pkg.sv */
// shared types and constants for the line position delta header encoder
`default_nettype none

package lpd_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CONT_BIT  = 8'h80;
  localparam logic [7:0] LOW7_MASK = 8'h7F;

  localparam logic [7:0] LINE_PRESENT_RESET    = 8'h04;
  localparam logic [7:0] LINE_NEGATIVE_RESET   = 8'h08;
  localparam logic [7:0] COLUMN_PRESENT_RESET  = 8'h10;
  localparam logic [7:0] COLUMN_NEGATIVE_RESET = 8'h20;

  typedef enum logic [1:0] {
    REG_LINE_PRESENT,
    REG_LINE_NEGATIVE,
    REG_COLUMN_PRESENT,
    REG_COLUMN_NEGATIVE
  } reg_index_t;

  typedef struct packed {
    logic [7:0] line_present;
    logic [7:0] line_negative;
    logic [7:0] column_present;
    logic [7:0] column_negative;
  } masks_t;

  typedef struct packed {
    logic [7:0]  kind;
    logic [7:0]  flags;
    logic [31:0] line_delta;
    logic [31:0] column_delta;
  } header_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

/* rtl/core/line_position_delta_header_encoder.sv */
// Line position delta header encoder, top level.
//
// Input channel item_valid/item_ready carries one node header: node_kind,
// base_flags, line_number and column_number. Output channel
// result_valid/result_ready carries one header byte per item (out_byte),
// with last_byte high on the final byte of each node's run.
// A node produces 2 to 12 bytes: kind, flags, then the nonzero line and
// column deltas as 7-bit varints. The byte sequencer sends one byte per
// cycle while result_ready allows; with the sequencer idle, a new node's
// first byte goes from its queue entry into the output register.
// The front end computes the deltas at acceptance and parks the header in
// a short queue (QUEUE_DEPTH entries), so new nodes are taken while the
// sequencer is still sending earlier ones; item_ready drops only when the
// queue is full.
// A stalled receiver holds the current byte in the output register; the
// queue then fills and the input stalls in turn.
// Synchronous reset (rst) zeroes the previous line and column, empties
// the queue and loads the default flag masks. Mask registers are written
// via cfg_we/cfg_index/cfg_data by the user only while idle; unenforced.
`default_nettype none

module line_position_delta_header_encoder #(
  parameter int unsigned QUEUE_DEPTH = lpd_pkg::QUEUE_DEPTH
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [7:0]  cfg_data,
  input  wire         item_valid,
  output logic        item_ready,
  input  wire  [7:0]  node_kind,
  input  wire  [7:0]  base_flags,
  input  wire  [31:0] line_number,
  input  wire  [31:0] column_number,
  output logic        result_valid,
  input  wire         result_ready,
  output logic [7:0]  out_byte,
  output logic        last_byte
);

  lpd_pkg::masks_t        masks;
  lpd_pkg::queue_status_t status;
  lpd_pkg::header_t       push_data;
  lpd_pkg::header_t       pop_data;
  logic                   push;
  logic                   pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      masks.line_present    <= lpd_pkg::LINE_PRESENT_RESET;
      masks.line_negative   <= lpd_pkg::LINE_NEGATIVE_RESET;
      masks.column_present  <= lpd_pkg::COLUMN_PRESENT_RESET;
      masks.column_negative <= lpd_pkg::COLUMN_NEGATIVE_RESET;
    end else if (cfg_we) begin
      case (lpd_pkg::reg_index_t'(cfg_index))
        lpd_pkg::REG_LINE_PRESENT:    masks.line_present    <= cfg_data;
        lpd_pkg::REG_LINE_NEGATIVE:   masks.line_negative   <= cfg_data;
        lpd_pkg::REG_COLUMN_PRESENT:  masks.column_present  <= cfg_data;
        lpd_pkg::REG_COLUMN_NEGATIVE: masks.column_negative <= cfg_data;
        default:                      masks                 <= masks;
      endcase
    end
  end

  lpd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .node_kind     (node_kind),
    .base_flags    (base_flags),
    .line_number   (line_number),
    .column_number (column_number),
    .masks         (masks),
    .status        (status),
    .push          (push),
    .push_data     (push_data)
  );

  lpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (status)
  );

  lpd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_data     (pop_data),
    .status       (status),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_byte     (out_byte),
    .last_byte    (last_byte)
  );

endmodule

`default_nettype wire

/* rtl/core/lpd_front.sv */
// front end: takes node items, works out line and column deltas and flags
`default_nettype none

module lpd_front (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   item_valid,
  output logic                  item_ready,
  input  wire  [7:0]            node_kind,
  input  wire  [7:0]            base_flags,
  input  wire  [31:0]           line_number,
  input  wire  [31:0]           column_number,
  input  lpd_pkg::masks_t       masks,
  input  lpd_pkg::queue_status_t status,
  output logic                  push,
  output lpd_pkg::header_t      push_data
);

  logic [31:0] previous_line;
  logic [31:0] previous_column;

  logic        line_up, line_down, column_up, column_down;
  logic [31:0] line_hi, line_lo, column_hi, column_lo;
  logic [7:0]  flags;

  always_comb begin
    line_up     = line_number > previous_line;
    line_down   = line_number < previous_line;
    column_up   = column_number > previous_column;
    column_down = column_number < previous_column;

    line_hi   = line_up ? line_number : previous_line;
    line_lo   = line_up ? previous_line : line_number;
    column_hi = column_up ? column_number : previous_column;
    column_lo = column_up ? previous_column : column_number;

    flags = base_flags;
    if (line_up || line_down) begin
      flags = flags | masks.line_present;
    end
    if (line_down) begin
      flags = flags | masks.line_negative;
    end
    if (column_up || column_down) begin
      flags = flags | masks.column_present;
    end
    if (column_down) begin
      flags = flags | masks.column_negative;
    end

    push_data.kind         = node_kind;
    push_data.flags        = flags;
    push_data.line_delta   = line_hi - line_lo;
    push_data.column_delta = column_hi - column_lo;

    item_ready = !status.full;
    push       = item_valid && !status.full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_line   <= '0;
      previous_column <= '0;
    end else if (push) begin
      previous_line   <= line_number;
      previous_column <= column_number;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lpd_queue.sv */
// short header queue between the front end and the byte sequencer
`default_nettype none

module lpd_queue #(
  parameter int unsigned DEPTH = lpd_pkg::QUEUE_DEPTH
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    push,
  input  lpd_pkg::header_t       push_data,
  input  wire                    pop,
  output lpd_pkg::header_t       pop_data,
  output lpd_pkg::queue_status_t status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  lpd_pkg::header_t entries [DEPTH];

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_comb begin
    status.full  = count == FULL_CNT;
    status.empty = count == '0;
    pop_data     = entries[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lpd_back.sv */
// byte sequencer: turns queued headers into the output byte stream
`default_nettype none

module lpd_back (
  input  wire                    clk,
  input  wire                    rst,
  input  lpd_pkg::header_t       pop_data,
  input  lpd_pkg::queue_status_t status,
  output logic                   pop,
  output logic                   result_valid,
  input  wire                    result_ready,
  output logic [7:0]             out_byte,
  output logic                   last_byte
);

  typedef enum logic [1:0] {
    IDLE,
    FLAGS,
    LINE,
    COLUMN
  } state_t;

  state_t      state;
  logic [7:0]  flags;
  logic [31:0] line_rest;
  logic [31:0] column_rest;

  logic advance;
  logic line_more, column_more;
  logic line_zero, column_zero;

  always_comb begin
    advance     = !result_valid || result_ready;
    pop         = advance && (state == IDLE) && !status.empty;
    line_more   = line_rest[31:7] != '0;
    column_more = column_rest[31:7] != '0;
    line_zero   = line_rest == '0;
    column_zero = column_rest == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      result_valid <= 1'b0;
    end else if (advance) begin
      case (state)
        IDLE: begin
          if (!status.empty) begin
            out_byte     <= pop_data.kind;
            last_byte    <= 1'b0;
            result_valid <= 1'b1;
            flags        <= pop_data.flags;
            line_rest    <= pop_data.line_delta;
            column_rest  <= pop_data.column_delta;
            state        <= FLAGS;
          end else begin
            result_valid <= 1'b0;
          end
        end
        FLAGS: begin
          out_byte     <= flags;
          last_byte    <= line_zero && column_zero;
          result_valid <= 1'b1;
          if (!line_zero) begin
            state <= LINE;
          end else if (!column_zero) begin
            state <= COLUMN;
          end else begin
            state <= IDLE;
          end
        end
        LINE: begin
          out_byte     <= (line_rest[7:0] & lpd_pkg::LOW7_MASK)
                          | (line_more ? lpd_pkg::CONT_BIT : 8'h00);
          last_byte    <= !line_more && column_zero;
          result_valid <= 1'b1;
          line_rest    <= {7'b0, line_rest[31:7]};
          if (!line_more) begin
            state <= column_zero ? IDLE : COLUMN;
          end
        end
        COLUMN: begin
          out_byte     <= (column_rest[7:0] & lpd_pkg::LOW7_MASK)
                          | (column_more ? lpd_pkg::CONT_BIT : 8'h00);
          last_byte    <= !column_more;
          result_valid <= 1'b1;
          column_rest  <= {7'b0, column_rest[31:7]};
          if (!column_more) begin
            state <= IDLE;
          end
        end
        default: begin
          state        <= IDLE;
          result_valid <= 1'b0;
        end
      endcase
    end
  end

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == LINE) |-> !line_zero)
    else $error("line phase entered with no line delta left");

  a_column_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == COLUMN) |-> !column_zero)
    else $error("column phase entered with no column delta left");

  a_pop_starts_run: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == FLAGS) && result_valid && !last_byte)
    else $error("popped header did not start a byte run");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_byte) |-> (state == IDLE))
    else $error("last byte shown while the sequencer is still busy");

endmodule

`default_nettype wire
